[sv/deadlock_detect_recover_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the deadlock detect and recover unit
// Shared property shapes, both disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEADLOCK_DETECT_RECOVER_UNIT_DEFINES_SVH
`define DEADLOCK_DETECT_RECOVER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ddr_pkg.sv]
// ----------------------------------------------------------------------------
// Deadlock detect and recover package
// Shared states, codes, defaults and field widths.
// ----------------------------------------------------------------------------
package ddr_pkg;

  localparam int DEF_MAX_THREADS   = 16;
  localparam int DEF_MAX_RESOURCES = 8;
  localparam int DEF_UNIT_BITS     = 8;

  localparam int ACTION_W    = 3;
  localparam int THREAD_ID_W = 4;
  localparam int RES_ID_W    = 3;
  localparam int AMOUNT_W    = 8;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 56;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_SET_CAP = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POST    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DETECT  = 3'd4;

  localparam logic [1:0] POL_ALL      = 2'd0;
  localparam logic [1:0] POL_TOTAL    = 2'd1;
  localparam logic [1:0] POL_BLOCKING = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_THREADS   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESOURCES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_POLICY    = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_ACQ_EV, ST_REL_RD, ST_REL_EV, ST_DET_INIT,
    ST_CHK_THR, ST_CHK_PRD, ST_CHK_PEV, ST_CHK_ARD, ST_CHK_AEV, ST_CHK_END,
    ST_ALL_THR, ST_KEY_THR, ST_KEY_RD, ST_KEY_EV, ST_SEL_SCAN, ST_SEL_PICK,
    ST_DONE
  } ddr_state_t;

  typedef struct packed {
    logic wr_alloc;
    logic wr_pend;
  } ddr_wr_t;

endpackage

[sv/ddr_table.sv]
// ----------------------------------------------------------------------------
// Allocation and pending tables
// Two single-port memories sharing one address, registered read,
// cleared by a sweep after reset.
// ----------------------------------------------------------------------------
`include "deadlock_detect_recover_unit_defines.svh"

module ddr_table #(
  parameter int MAX_THREADS   = 16,
  parameter int MAX_RESOURCES = 8,
  parameter int UNIT_BITS     = 8,
  localparam int TB = $clog2(MAX_THREADS),
  localparam int RB = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
  localparam int AW = TB + RB
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [AW-1:0]        addr_i,
  input  ddr_pkg::ddr_wr_t     wr_i,
  input  logic [UNIT_BITS-1:0] alloc_wdata_i,
  input  logic [UNIT_BITS-1:0] pend_wdata_i,
  output logic [UNIT_BITS-1:0] alloc_rdata_o,
  output logic [UNIT_BITS-1:0] pend_rdata_o,
  output logic                 busy_o
);
  import ddr_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [UNIT_BITS-1:0] alloc_mem [DEPTH];
  logic [UNIT_BITS-1:0] pend_mem  [DEPTH];
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 clearing_r, clearing_nxt;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      alloc_mem[clr_addr_r] <= '0;
    end else if (wr_i.wr_alloc) begin
      alloc_mem[addr_i] <= alloc_wdata_i;
    end
    alloc_rdata_o <= alloc_mem[addr_i];
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      pend_mem[clr_addr_r] <= '0;
    end else if (wr_i.wr_pend) begin
      pend_mem[addr_i] <= pend_wdata_i;
    end
    pend_rdata_o <= pend_mem[addr_i];
  end

  assign busy_o = clearing_r;

  `DDR_ASSERT_NOW(a_no_write_in_sweep, clk, rst_n, clearing_r, !wr_i.wr_alloc && !wr_i.wr_pend, "table write during clearing sweep")
  `DDR_ASSERT_NEXT(a_sweep_runs_once, clk, rst_n, !clearing_r, !clearing_r, "clearing sweep restarted")
  `DDR_ASSERT_NEXT(a_sweep_continues, clk, rst_n, clearing_r && (clr_addr_r != AW'(DEPTH - 1)), clearing_r, "clearing sweep ended early")

endmodule

[sv/deadlock_detect_recover_unit.sv]
// Flow: release all walks every resource column of the thread; detect runs up
//   to nt passes over nt threads, a request test over the resources and, for a
//   thread that passes, a merge of its holdings into the work vector.
// Throughput: one transfer at a time; the shared table read port sets the rate.
// Reset: synchronous active low; afterwards a clearing sweep over
//   all table entries (128 by default) holds in_tready low.
// ----------------------------------------------------------------------------
// Deadlock detect and recover unit
// Resource allocation table with repeated-pass safety check and victim
// based recovery, built around one shared table memory.
// ----------------------------------------------------------------------------
`include "deadlock_detect_recover_unit_defines.svh"

module deadlock_detect_recover_unit #(
  parameter int MAX_THREADS   = ddr_pkg::DEF_MAX_THREADS,
  parameter int MAX_RESOURCES = ddr_pkg::DEF_MAX_RESOURCES,
  parameter int UNIT_BITS     = ddr_pkg::DEF_UNIT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream. tuser: action[2:0].
  // tdata: thread_id[3:0], resource_id[6:4], amount[14:7], zero fill [15].
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ddr_pkg::ACTION_W-1:0]     in_tuser,
  input  logic [ddr_pkg::IN_DATA_W-1:0]    in_tdata,
  // Result stream. tdata: granted[0], deadlock_found[1],
  // deadlocked_mask[17:2], victim_mask[33:18], victim_count[38:34],
  // blocking_mask[46:39], available_now[54:47], zero fill [55].
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ddr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [ddr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ddr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ddr_pkg::*;

  // Table rows are threads and columns are resources; the memory address is
  // {thread, resource}. Counters are sized by $clog2(N+1) so that they can
  // hold the count of active rows or columns itself.
  localparam int TB  = $clog2(MAX_THREADS);
  localparam int RB  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int CTW = $clog2(MAX_THREADS + 1);
  localparam int CRW = $clog2(MAX_RESOURCES + 1);
  localparam int UB  = UNIT_BITS;
  localparam int KW  = UNIT_BITS + $clog2(MAX_RESOURCES);

  function automatic logic [UB-1:0] sat_add(input logic [UB-1:0] a,
                                            input logic [UB-1:0] b);
    logic [UB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UB] ? {UB{1'b1}} : s[UB-1:0];
  endfunction

  // Configuration registers.
  logic [4:0] thr_cfg_r;
  logic [3:0] res_cfg_r;
  logic [1:0] pol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_cfg_r <= 5'd16;
      res_cfg_r <= 4'd8;
      pol_r     <= POL_ALL;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_THREADS:   thr_cfg_r <= cfg_wdata[4:0];
        CFG_RESOURCES: res_cfg_r <= cfg_wdata[3:0];
        CFG_POLICY:    pol_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Item and control state.
  ddr_state_t state_r, state_nxt;
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [TB-1:0]       tid_r, tid_nxt;
  logic                t_ok_r, t_ok_nxt;
  logic [RB-1:0]       rid_r, rid_nxt;
  logic                r_ok_r, r_ok_nxt;
  logic [UB-1:0]       amt_r, amt_nxt;
  logic [CTW-1:0]      pass_r, pass_nxt;
  logic [CTW-1:0]      i_r, i_nxt;
  logic [CRW-1:0]      j_r, j_nxt;
  logic                ok_r, ok_nxt;
  logic                first_r, first_nxt;
  logic                relv_r, relv_nxt;
  logic                have_r, have_nxt;
  logic                granted_r, granted_nxt;
  logic                found_r, found_nxt;
  logic [MAX_THREADS-1:0]   fin_r, fin_nxt;
  logic [MAX_THREADS-1:0]   dead_r, dead_nxt;
  logic [MAX_THREADS-1:0]   victims_r, victims_nxt;
  logic [MAX_THREADS-1:0]   cand_r, cand_nxt;
  logic [MAX_RESOURCES-1:0] blk_r, blk_nxt;
  logic [CTW-1:0]      vcount_r, vcount_nxt;
  logic [TB-1:0]       best_r, best_nxt;
  logic [KW-1:0]       bestkey_r, bestkey_nxt;
  logic [KW-1:0]       acc_r, acc_nxt;
  logic [UB-1:0]       avail_r [MAX_RESOURCES];
  logic [UB-1:0]       avail_nxt [MAX_RESOURCES];
  logic [UB-1:0]       work_r [MAX_RESOURCES];
  logic [UB-1:0]       work_nxt [MAX_RESOURCES];
  logic [KW-1:0]       key_r [MAX_THREADS];
  logic [KW-1:0]       key_nxt [MAX_THREADS];
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Table memory port.
  logic [TB+RB-1:0] mem_addr;
  ddr_wr_t          mem_wr;
  logic [UB-1:0]    alloc_wdata, pend_wdata, alloc_rd, pend_rd;
  logic             tbl_busy;

  ddr_table #(
    .MAX_THREADS  (MAX_THREADS),
    .MAX_RESOURCES(MAX_RESOURCES),
    .UNIT_BITS    (UNIT_BITS)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .addr_i       (mem_addr),
    .wr_i         (mem_wr),
    .alloc_wdata_i(alloc_wdata),
    .pend_wdata_i (pend_wdata),
    .alloc_rdata_o(alloc_rd),
    .pend_rdata_o (pend_rd),
    .busy_o       (tbl_busy)
  );

  // Effective row and column counts, clamped to the table size.
  logic [CTW-1:0] nt;
  logic [CRW-1:0] nr;
  logic [MAX_THREADS-1:0] nt_mask;
  logic [TB-1:0]  tix;
  logic [RB-1:0]  jix;
  logic           i_end, pass_end, last_jc, last_jr, gt, acq_ok, all_fin;
  logic           out_free;

  assign nt = (32'(thr_cfg_r) > MAX_THREADS) ? CTW'(MAX_THREADS) : CTW'(thr_cfg_r);
  assign nr = (32'(res_cfg_r) > MAX_RESOURCES) ? CRW'(MAX_RESOURCES) : CRW'(res_cfg_r);

  always_comb begin
    for (int k = 0; k < MAX_THREADS; k++) begin
      nt_mask[k] = (k < 32'(nt));
    end
  end

  assign tix      = i_r[TB-1:0];
  assign jix      = j_r[RB-1:0];
  assign i_end    = (i_r == nt);
  assign pass_end = (pass_r == nt);
  assign last_jc  = (j_r == nr - 1'b1);
  assign last_jr  = (j_r == CRW'(MAX_RESOURCES - 1));
  assign gt       = (pend_rd > work_r[jix]);
  assign acq_ok   = (pend_rd != '0) && (avail_r[rid_r] >= pend_rd);
  assign all_fin  = ((fin_r & nt_mask) == nt_mask);
  assign out_free = !out_tvalid_r || out_tready;

  // The check and key walks address the table by the loop counters; the
  // single-item actions use the latched thread and resource.
  always_comb begin
    logic [TB-1:0] row;
    logic [RB-1:0] col;
    row = tid_r;
    col = jix;
    case (state_r)
      ST_CHK_PRD, ST_CHK_PEV, ST_CHK_ARD, ST_CHK_AEV, ST_KEY_RD, ST_KEY_EV: row = tix;
      ST_EXEC, ST_ACQ_EV: col = rid_r;
      default: ;
    endcase
    mem_addr = {row, col};
  end

  assign in_tready = (state_r == ST_IDLE) && !tbl_busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (act_r)
          ACT_ACQUIRE: if (t_ok_r && r_ok_r) state_nxt = ST_ACQ_EV;
          ACT_RELEASE: if (t_ok_r) state_nxt = ST_REL_RD;
          ACT_DETECT:  state_nxt = ST_DET_INIT;
          default: ;
        endcase
      end
      ST_ACQ_EV: state_nxt = ST_DONE;
      ST_REL_RD: state_nxt = ST_REL_EV;
      ST_REL_EV: begin
        if (last_jr) begin
          if (!relv_r) state_nxt = ST_DONE;
          else if (pol_r == POL_ALL) state_nxt = ST_ALL_THR;
          else state_nxt = ST_DET_INIT;
        end else begin
          state_nxt = ST_REL_RD;
        end
      end
      ST_DET_INIT: state_nxt = ST_CHK_THR;
      ST_CHK_THR: begin
        if (pass_end) state_nxt = ST_CHK_END;
        else if (!i_end && !fin_r[tix] && nr != '0) state_nxt = ST_CHK_PRD;
      end
      ST_CHK_PRD: state_nxt = ST_CHK_PEV;
      ST_CHK_PEV: begin
        if (!last_jc) state_nxt = ST_CHK_PRD;
        else if (ok_r && !gt) state_nxt = ST_CHK_ARD;
        else state_nxt = ST_CHK_THR;
      end
      ST_CHK_ARD: state_nxt = ST_CHK_AEV;
      ST_CHK_AEV: state_nxt = last_jc ? ST_CHK_THR : ST_CHK_ARD;
      ST_CHK_END: begin
        if (first_r) begin
          if ((nt_mask & ~fin_r) == '0) state_nxt = ST_DONE;
          else if (pol_r == POL_ALL) state_nxt = ST_ALL_THR;
          else if (pol_r == POL_TOTAL || pol_r == POL_BLOCKING) state_nxt = ST_KEY_THR;
          else state_nxt = ST_DONE;
        end else if (all_fin || cand_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SEL_SCAN;
        end
      end
      ST_ALL_THR: begin
        if (i_end) state_nxt = ST_DONE;
        else if (dead_r[tix]) state_nxt = ST_REL_RD;
      end
      ST_KEY_THR: begin
        if (i_end) state_nxt = ST_SEL_SCAN;
        else if (dead_r[tix] && nr != '0) state_nxt = ST_KEY_RD;
      end
      ST_KEY_RD: state_nxt = ST_KEY_EV;
      ST_KEY_EV: state_nxt = last_jc ? ST_KEY_THR : ST_KEY_RD;
      ST_SEL_SCAN: if (i_end) state_nxt = ST_SEL_PICK;
      ST_SEL_PICK: state_nxt = ST_REL_RD;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and table port.
  always_comb begin
    act_nxt     = act_r;
    tid_nxt     = tid_r;
    t_ok_nxt    = t_ok_r;
    rid_nxt     = rid_r;
    r_ok_nxt    = r_ok_r;
    amt_nxt     = amt_r;
    pass_nxt    = pass_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    ok_nxt      = ok_r;
    first_nxt   = first_r;
    relv_nxt    = relv_r;
    have_nxt    = have_r;
    granted_nxt = granted_r;
    found_nxt   = found_r;
    fin_nxt     = fin_r;
    dead_nxt    = dead_r;
    victims_nxt = victims_r;
    cand_nxt    = cand_r;
    blk_nxt     = blk_r;
    vcount_nxt  = vcount_r;
    best_nxt    = best_r;
    bestkey_nxt = bestkey_r;
    acc_nxt     = acc_r;
    avail_nxt   = avail_r;
    work_nxt    = work_r;
    key_nxt     = key_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mem_wr      = '0;
    alloc_wdata = '0;
    pend_wdata  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          act_nxt     = in_tuser;
          tid_nxt     = TB'(in_tdata[3:0]);
          t_ok_nxt    = (32'(in_tdata[3:0]) < MAX_THREADS);
          rid_nxt     = RB'(in_tdata[6:4]);
          r_ok_nxt    = (32'(in_tdata[6:4]) < MAX_RESOURCES);
          amt_nxt     = UB'(in_tdata[14:7]);
          granted_nxt = 1'b0;
          found_nxt   = 1'b0;
          fin_nxt     = '0;
          dead_nxt    = '0;
          victims_nxt = '0;
          vcount_nxt  = '0;
          blk_nxt     = '0;
          first_nxt   = 1'b1;
          relv_nxt    = 1'b0;
          j_nxt       = '0;
        end
      end
      ST_EXEC: begin
        case (act_r)
          ACT_SET_CAP: if (r_ok_r) avail_nxt[rid_r] = amt_r;
          ACT_POST: begin
            if (t_ok_r && r_ok_r) begin
              mem_wr.wr_pend = 1'b1;
              pend_wdata     = amt_r;
            end
          end
          default: ;
        endcase
      end
      ST_ACQ_EV: begin
        if (acq_ok) begin
          avail_nxt[rid_r] = avail_r[rid_r] - pend_rd;
          mem_wr.wr_alloc  = 1'b1;
          mem_wr.wr_pend   = 1'b1;
          alloc_wdata      = sat_add(alloc_rd, pend_rd);
          granted_nxt      = 1'b1;
        end
      end
      ST_REL_EV: begin
        avail_nxt[jix]  = sat_add(avail_r[jix], alloc_rd);
        mem_wr.wr_alloc = 1'b1;
        mem_wr.wr_pend  = relv_r;
        if (last_jr) begin
          if (relv_r) begin
            if (pol_r == POL_ALL) begin
              i_nxt = i_r + 1'b1;
            end else begin
              fin_nxt   = victims_r;
              first_nxt = 1'b0;
            end
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DET_INIT: begin
        for (int k = 0; k < MAX_RESOURCES; k++) work_nxt[k] = avail_r[k];
        pass_nxt = '0;
        i_nxt    = '0;
      end
      ST_CHK_THR: begin
        if (!pass_end) begin
          if (i_end) begin
            pass_nxt = pass_r + 1'b1;
            i_nxt    = '0;
          end else if (fin_r[tix]) begin
            i_nxt = i_r + 1'b1;
          end else if (nr == '0) begin
            fin_nxt[tix] = 1'b1;
            i_nxt        = i_r + 1'b1;
          end else begin
            j_nxt  = '0;
            ok_nxt = 1'b1;
          end
        end
      end
      ST_CHK_PEV: begin
        if (gt) begin
          ok_nxt = 1'b0;
          if (first_r) blk_nxt[jix] = 1'b1;
        end
        if (!last_jc) j_nxt = j_r + 1'b1;
        else if (ok_r && !gt) j_nxt = '0;
        else i_nxt = i_r + 1'b1;
      end
      ST_CHK_AEV: begin
        work_nxt[jix] = sat_add(work_r[jix], alloc_rd);
        if (last_jc) begin
          fin_nxt[tix] = 1'b1;
          i_nxt        = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_CHK_END: begin
        i_nxt    = '0;
        have_nxt = 1'b0;
        if (first_r) begin
          dead_nxt  = nt_mask & ~fin_r;
          found_nxt = ((nt_mask & ~fin_r) != '0);
        end
      end
      ST_ALL_THR: begin
        if (!i_end) begin
          if (dead_r[tix]) begin
            tid_nxt           = tix;
            relv_nxt          = 1'b1;
            j_nxt             = '0;
            victims_nxt[tix]  = 1'b1;
            vcount_nxt        = vcount_r + 1'b1;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      ST_KEY_THR: begin
        if (i_end) begin
          cand_nxt = dead_r;
          i_nxt    = '0;
          have_nxt = 1'b0;
        end else if (dead_r[tix] && nr != '0) begin
          acc_nxt = '0;
          j_nxt   = '0;
        end else begin
          key_nxt[tix] = '0;
          i_nxt        = i_r + 1'b1;
        end
      end
      ST_KEY_EV: begin
        if (pol_r == POL_TOTAL || blk_r[jix]) acc_nxt = acc_r + KW'(alloc_rd);
        if (last_jc) begin
          key_nxt[tix] = acc_nxt;
          i_nxt        = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_SEL_SCAN: begin
        if (!i_end) begin
          if (cand_r[tix] && (!have_r || key_r[tix] > bestkey_r)) begin
            best_nxt    = tix;
            bestkey_nxt = key_r[tix];
            have_nxt    = 1'b1;
          end
          i_nxt = i_r + 1'b1;
        end
      end
      ST_SEL_PICK: begin
        cand_nxt[best_r]    = 1'b0;
        tid_nxt             = best_r;
        relv_nxt            = 1'b1;
        j_nxt               = '0;
        victims_nxt[best_r] = 1'b1;
        vcount_nxt          = vcount_r + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0,
                            (r_ok_r ? 8'(avail_r[rid_r]) : 8'd0),
                            8'(blk_r),
                            5'(vcount_r),
                            16'(victims_r),
                            16'(dead_r),
                            found_r,
                            granted_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      first_r      <= 1'b1;
      relv_r       <= 1'b0;
      have_r       <= 1'b0;
      dead_r       <= '0;
      victims_r    <= '0;
      vcount_r     <= '0;
      for (int k = 0; k < MAX_RESOURCES; k++) avail_r[k] <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      first_r      <= first_nxt;
      relv_r       <= relv_nxt;
      have_r       <= have_nxt;
      dead_r       <= dead_nxt;
      victims_r    <= victims_nxt;
      vcount_r     <= vcount_nxt;
      avail_r      <= avail_nxt;
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    tid_r       <= tid_nxt;
    t_ok_r      <= t_ok_nxt;
    rid_r       <= rid_nxt;
    r_ok_r      <= r_ok_nxt;
    amt_r       <= amt_nxt;
    pass_r      <= pass_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    ok_r        <= ok_nxt;
    granted_r   <= granted_nxt;
    found_r     <= found_nxt;
    fin_r       <= fin_nxt;
    cand_r      <= cand_nxt;
    blk_r       <= blk_nxt;
    best_r      <= best_nxt;
    bestkey_r   <= bestkey_nxt;
    acc_r       <= acc_nxt;
    work_r      <= work_nxt;
    key_r       <= key_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `DDR_ASSERT_NOW(a_vcount_matches, clk, rst_n, 1'b1, 32'(vcount_r) == $countones(victims_r), "victim count out of step with victim mask")
  `DDR_ASSERT_NOW(a_victims_deadlocked, clk, rst_n, 1'b1, (victims_r & ~dead_r) == '0, "victim outside the deadlocked set")
  `DDR_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r == ST_EXEC, "accepted transfer not started")

endmodule
